[rtl/plm_pkg.sv]
// Shared types, constants and helper functions for the peak level LED meter.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
`default_nettype none
package plm_pkg;

    // Meter channels and LED layout
    localparam int CHANNELS       = 4;
    localparam int ALT_LED_LAYOUT = 0;
    localparam int CH_IDX_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Field widths
    localparam int CH_W    = 2;
    localparam int LEVEL_W = 16;
    localparam int BRT_W   = 12;
    localparam int REG_W   = 8;
    localparam int CNT_W   = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLIP_LEVEL   = 3'd0,
        CFG_OFF_LEVEL    = 3'd1,
        CFG_GREEN_LIMIT  = 3'd2,
        CFG_YELLOW_LIMIT = 3'd3,
        CFG_SMOOTH_W     = 3'd4,
        CFG_BRIGHT_RED   = 3'd5,
        CFG_DIM_LEVEL    = 3'd6
    } t_cfg_idx;

    localparam logic [LEVEL_W-1:0] RST_CLIP_LEVEL   = 16'd16187;
    localparam logic [LEVEL_W-1:0] RST_OFF_LEVEL    = 16'd147;
    localparam logic [LEVEL_W-1:0] RST_GREEN_LIMIT  = 16'd8192;
    localparam logic [LEVEL_W-1:0] RST_YELLOW_LIMIT = 16'd14746;
    localparam logic [LEVEL_W-1:0] RST_SMOOTH_W     = 16'd6554;
    localparam logic [BRT_W-1:0]   RST_BRIGHT_RED   = 12'd1024;
    localparam logic [BRT_W-1:0]   RST_DIM_LEVEL    = 12'd120;

    // Clip counter thresholds
    localparam logic [CNT_W-1:0] CLIP_BRIGHT_END = 4'd5;
    localparam logic [CNT_W-1:0] CLIP_LAST       = 4'd8;

    // Color codes and PWM register layout
    localparam logic COLOR_RED   = 1'b0;
    localparam logic COLOR_GREEN = 1'b1;
    localparam logic [REG_W-1:0] PWM_BASE  = 8'd8;
    localparam logic [REG_W-1:0] PWM_RED   = 8'd4;   // color index 1, times 4
    localparam logic [REG_W-1:0] PWM_GREEN = 8'd8;   // color index 2, times 4

    // Brightness curve constants
    localparam logic [LEVEL_W-1:0] YELLOW_BASE = 16'd8192;
    localparam logic [BRT_W-1:0]   BRT_FLOOR   = 12'd10;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [CH_W-1:0]    ch;
        logic [LEVEL_W-1:0] peak;
        logic               clip;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

    typedef struct packed {
        logic [LEVEL_W-1:0] clip_level;
        logic [LEVEL_W-1:0] off_level;
        logic [LEVEL_W-1:0] green_limit;
        logic [LEVEL_W-1:0] yellow_limit;
        logic [LEVEL_W-1:0] smooth_w;
        logic [BRT_W-1:0]   bright_red;
        logic [BRT_W-1:0]   dim_level;
    } t_cfg;

    // Fixed channel-to-LED map
    function automatic logic [CH_W-1:0] led_map(input logic [CH_W-1:0] ch);
        logic [CH_W-1:0] led;
        led = 2'd0;
        if (ALT_LED_LAYOUT != 0) begin
            case (ch)
                2'd0:    led = 2'd3;
                2'd1:    led = 2'd2;
                2'd2:    led = 2'd0;
                default: led = 2'd1;
            endcase
        end else begin
            case (ch)
                2'd0:    led = 2'd2;
                2'd1:    led = 2'd3;
                2'd2:    led = 2'd1;
                default: led = 2'd0;
            endcase
        end
        return led;
    endfunction

endpackage
`default_nettype wire

[rtl/plm_front.sv]
// Front end: input handshake, clip classification and a short item queue.
// Depends on plm_pkg.
`default_nettype none
module plm_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [plm_pkg::CH_W-1:0]    i_meter_channel,
    input  wire logic [plm_pkg::LEVEL_W-1:0] i_peak_level,
    input  wire logic [plm_pkg::LEVEL_W-1:0] i_clip_level,
    output plm_pkg::t_q_head                 o_head,
    input  wire logic                        i_pop
);

    plm_pkg::t_item                    r_mem [plm_pkg::QDEPTH];
    logic [plm_pkg::QPTR_W-1:0]        r_wr_ptr;
    logic [plm_pkg::QPTR_W-1:0]        r_rd_ptr;
    logic [plm_pkg::QCNT_W-1:0]        r_count;
    logic                              accept;
    logic                              in_range;
    logic                              push;
    logic                              pop;
    plm_pkg::t_item                    new_item;

    // Transaction accepted whenever the queue has room
    assign o_in_stall = (r_count == plm_pkg::QCNT_W'(plm_pkg::QDEPTH));
    assign accept     = i_in_valid && !o_in_stall;

    // Channels beyond the configured count are dropped here
    assign in_range = ({3'b000, i_meter_channel} < 5'(plm_pkg::CHANNELS));
    assign push     = accept && in_range;
    assign pop      = i_pop && (r_count != '0);

    // Classify: clipping when the peak is strictly above the clip level
    always_comb begin
        new_item.ch   = i_meter_channel;
        new_item.peak = i_peak_level;
        new_item.clip = (i_peak_level > i_clip_level);
    end

    // Queue storage (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= new_item;
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == plm_pkg::QPTR_W'(plm_pkg::QDEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == plm_pkg::QPTR_W'(plm_pkg::QDEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

endmodule
`default_nettype wire

[rtl/plm_back.sv]
// Back end: smoothing, clip counting, color selection, cache compare and
// the output register for PWM write transactions. Depends on plm_pkg.
`default_nettype none
module plm_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire plm_pkg::t_cfg               i_cfg,
    input  wire plm_pkg::t_q_head            i_head,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [plm_pkg::CH_W-1:0]         o_led_position,
    output logic                             o_color_code,
    output logic [plm_pkg::BRT_W-1:0]        o_brightness,
    output logic [plm_pkg::REG_W-1:0]        o_pwm_register,
    output logic                             o_last_write
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LEVEL = 5'b00010,
        S_COLOR = 5'b00100,
        S_RED   = 5'b01000,
        S_GREEN = 5'b10000
    } t_state;

    t_state                              r_state;
    logic [plm_pkg::CNT_W-1:0]           r_clip_cnt    [plm_pkg::CHANNELS];
    logic [plm_pkg::LEVEL_W-1:0]         r_level       [plm_pkg::CHANNELS];
    logic [plm_pkg::BRT_W-1:0]           r_cache_red   [plm_pkg::CHANNELS];
    logic [plm_pkg::BRT_W-1:0]           r_cache_green [plm_pkg::CHANNELS];

    logic [plm_pkg::CH_W-1:0]            r_ch;
    logic                                r_clip;
    logic [plm_pkg::LEVEL_W-1:0]         r_f;
    logic [plm_pkg::LEVEL_W-1:0]         r_prod_hi;
    logic [plm_pkg::LEVEL_W-1:0]         r_v;
    logic                                r_bright;
    logic [plm_pkg::BRT_W-1:0]           r_red;
    logic [plm_pkg::BRT_W-1:0]           r_green;
    logic                                r_red_chg;
    logic                                r_green_chg;

    logic [plm_pkg::CH_IDX_W-1:0]        head_idx;
    logic [plm_pkg::CH_IDX_W-1:0]        cur_idx;
    logic [plm_pkg::LEVEL_W-1:0]         head_f;
    logic signed [16:0]                  diff;
    logic signed [33:0]                  prod;
    logic [plm_pkg::LEVEL_W-1:0]         n_v;
    logic [plm_pkg::CNT_W-1:0]           cnt_inc;
    logic [plm_pkg::LEVEL_W-1:0]         yel_d;
    logic [21:0]                         green_mul;
    logic [24:0]                         red_mul;
    logic [plm_pkg::BRT_W-1:0]           n_red;
    logic [plm_pkg::BRT_W-1:0]           n_green;
    logic                                out_free;
    logic                                out_load;
    logic [plm_pkg::CH_W-1:0]            led;

    assign head_idx = plm_pkg::CH_IDX_W'(i_head.item.ch);
    assign cur_idx  = plm_pkg::CH_IDX_W'(r_ch);
    assign head_f   = r_level[head_idx];
    assign out_free = !o_out_valid || !i_out_stall;
    assign out_load = ((r_state == S_RED) || (r_state == S_GREEN)) && out_free;
    assign o_pop    = (r_state == S_IDLE) && i_head.valid;
    assign led      = plm_pkg::led_map(r_ch);

    // Smoothing as f + w*(p-f)/65536, one signed 17x17 multiply
    assign diff = $signed({1'b0, i_head.item.peak}) - $signed({1'b0, head_f});
    assign prod = 34'(diff) * $signed({1'b0, i_cfg.smooth_w});

    assign n_v     = r_f + r_prod_hi;
    assign cnt_inc = r_clip_cnt[cur_idx] + 1'b1;

    // Color bands from the filtered level
    assign yel_d     = (r_v > plm_pkg::YELLOW_BASE) ? r_v - plm_pkg::YELLOW_BASE : '0;
    assign green_mul = 22'(r_v) * 22'd55;
    assign red_mul   = 25'(yel_d) * 25'd275;

    always_comb begin
        n_red   = '0;
        n_green = '0;
        if (r_clip) begin
            n_red = r_bright ? i_cfg.bright_red : i_cfg.dim_level;
        end else if (r_v < i_cfg.off_level) begin
            n_red   = '0;
        end else if (r_v < i_cfg.green_limit) begin
            n_green = plm_pkg::BRT_FLOOR + plm_pkg::BRT_W'(green_mul[21:12]);
        end else if (r_v < i_cfg.yellow_limit) begin
            n_red   = plm_pkg::BRT_FLOOR + plm_pkg::BRT_W'(red_mul[24:14]);
            n_green = i_cfg.dim_level;
        end else begin
            n_red   = i_cfg.dim_level;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
            for (int i = 0; i < plm_pkg::CHANNELS; i++) begin
                r_clip_cnt[i]    <= '0;
                r_level[i]       <= '0;
                r_cache_red[i]   <= '0;
                r_cache_green[i] <= '0;
            end
        end else begin
            // Output valid: set on a new write, dropped once taken
            if (out_load) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_state <= S_LEVEL;
                    end
                end
                S_LEVEL: begin
                    // Clip counter update; level only moves when not clipping
                    if (r_clip) begin
                        if (cnt_inc < plm_pkg::CLIP_BRIGHT_END) begin
                            r_clip_cnt[cur_idx] <= cnt_inc;
                        end else begin
                            r_clip_cnt[cur_idx] <= (cnt_inc > plm_pkg::CLIP_LAST) ?
                                                   '0 : cnt_inc;
                        end
                    end else begin
                        r_clip_cnt[cur_idx] <= '0;
                        r_level[cur_idx]    <= n_v;
                    end
                    r_state <= S_COLOR;
                end
                S_COLOR: begin
                    if (n_red != r_cache_red[cur_idx]) begin
                        r_state <= S_RED;
                    end else if (n_green != r_cache_green[cur_idx]) begin
                        r_state <= S_GREEN;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_RED: begin
                    if (out_free) begin
                        r_cache_red[cur_idx] <= r_red;
                        r_state              <= r_green_chg ? S_GREEN : S_IDLE;
                    end
                end
                S_GREEN: begin
                    if (out_free) begin
                        r_cache_green[cur_idx] <= r_green;
                        r_state                <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers (no reset)
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_ch      <= i_head.item.ch;
                r_clip    <= i_head.item.clip;
                r_f       <= head_f;
                r_prod_hi <= prod[31:16];
            end
            S_LEVEL: begin
                r_v      <= r_clip ? r_f : n_v;
                r_bright <= (cnt_inc < plm_pkg::CLIP_BRIGHT_END);
            end
            S_COLOR: begin
                r_red       <= n_red;
                r_green     <= n_green;
                r_red_chg   <= (n_red != r_cache_red[cur_idx]);
                r_green_chg <= (n_green != r_cache_green[cur_idx]);
            end
            S_RED: begin
                if (out_free) begin
                    o_led_position <= led;
                    o_color_code   <= plm_pkg::COLOR_RED;
                    o_brightness   <= r_red;
                    o_pwm_register <= plm_pkg::PWM_BASE + {2'b00, led, 4'b0000}
                                      + plm_pkg::PWM_RED;
                    o_last_write   <= !r_green_chg;
                end
            end
            S_GREEN: begin
                if (out_free) begin
                    o_led_position <= led;
                    o_color_code   <= plm_pkg::COLOR_GREEN;
                    o_brightness   <= r_green;
                    o_pwm_register <= plm_pkg::PWM_BASE + {2'b00, led, 4'b0000}
                                      + plm_pkg::PWM_GREEN;
                    o_last_write   <= 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

[rtl/peak_level_led_meter_unit.sv]
// Peak level LED meter top level: configuration registers, front end with
// queue, back end with output register. Depends on plm_pkg, plm_front, plm_back.
// Path: an input sample goes through the queue, multiply, level and color stages
// to its first PWM write, if any; a second write, when both colors change, follows.
// The back-end sequencer takes one sample at a time: idle, level and color states
// plus one write state per changed element, holding while the output is stalled.
// Reset (synchronous, active low): registers take their defaults, all channel
// state and the brightness cache clear at once, queue and output empty.
`default_nettype none
module peak_level_led_meter_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Configuration port
    input  wire logic                          i_cfg_we,
    input  wire logic [plm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [plm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [plm_pkg::CH_W-1:0]      i_meter_channel,
    input  wire logic [plm_pkg::LEVEL_W-1:0]   i_peak_level,
    // Output channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [plm_pkg::CH_W-1:0]           o_led_position,
    output logic                               o_color_code,
    output logic [plm_pkg::BRT_W-1:0]          o_brightness,
    output logic [plm_pkg::REG_W-1:0]          o_pwm_register,
    output logic                               o_last_write
);

    plm_pkg::t_cfg    r_cfg;
    plm_pkg::t_q_head head;
    logic             pop;

    // Configuration registers; writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clip_level   <= plm_pkg::RST_CLIP_LEVEL;
            r_cfg.off_level    <= plm_pkg::RST_OFF_LEVEL;
            r_cfg.green_limit  <= plm_pkg::RST_GREEN_LIMIT;
            r_cfg.yellow_limit <= plm_pkg::RST_YELLOW_LIMIT;
            r_cfg.smooth_w     <= plm_pkg::RST_SMOOTH_W;
            r_cfg.bright_red   <= plm_pkg::RST_BRIGHT_RED;
            r_cfg.dim_level    <= plm_pkg::RST_DIM_LEVEL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                plm_pkg::CFG_CLIP_LEVEL:   r_cfg.clip_level   <= i_cfg_data;
                plm_pkg::CFG_OFF_LEVEL:    r_cfg.off_level    <= i_cfg_data;
                plm_pkg::CFG_GREEN_LIMIT:  r_cfg.green_limit  <= i_cfg_data;
                plm_pkg::CFG_YELLOW_LIMIT: r_cfg.yellow_limit <= i_cfg_data;
                plm_pkg::CFG_SMOOTH_W:     r_cfg.smooth_w     <= i_cfg_data;
                plm_pkg::CFG_BRIGHT_RED:   r_cfg.bright_red   <= i_cfg_data[11:0];
                plm_pkg::CFG_DIM_LEVEL:    r_cfg.dim_level    <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    plm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_meter_channel (i_meter_channel),
        .i_peak_level    (i_peak_level),
        .i_clip_level    (r_cfg.clip_level),
        .o_head          (head),
        .i_pop           (pop)
    );

    plm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_head         (head),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_led_position (o_led_position),
        .o_color_code   (o_color_code),
        .o_brightness   (o_brightness),
        .o_pwm_register (o_pwm_register),
        .o_last_write   (o_last_write)
    );

endmodule
`default_nettype wire
